[rtl/core/epsm_pkg.sv]
// Shared types and constants for the encoder period speed meter.
package epsm_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int MAX_RESULTS  = 4;
  localparam int QUO_W        = 20;
  localparam int STEP_W       = 5;

  localparam logic [QUO_W-1:0] SPEED_NUM_Q4 = 20'd960000;

  localparam logic [15:0] DEBOUNCE_RST = 16'd2;
  localparam logic [15:0] TIMEOUT_RST  = 16'd500;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_PULSE  = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;

  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic div_step;
    logic put;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic speed_zero;
    logic last_chan;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/core/epsm_regs.sv]
// Configuration registers behind the APB-style port.
module epsm_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] debounce_floor_ms,
  output logic [15:0] stall_timeout_ms
);
  import epsm_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_floor_ms <= DEBOUNCE_RST;
      stall_timeout_ms  <= TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_DEBOUNCE: debounce_floor_ms <= pwdata[15:0];
        REG_TIMEOUT:  stall_timeout_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEBOUNCE: prdata = {16'b0, debounce_floor_ms};
      REG_TIMEOUT:  prdata = {16'b0, stall_timeout_ms};
      default:      prdata = '0;
    endcase
  end

endmodule

[rtl/core/epsm_ctrl.sv]
// Sequencing state machine: item intake and per-wheel sample sequence.
module epsm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           action,
  output logic                 in_stall,
  output epsm_pkg::dp_cmd_t    cmd,
  input  epsm_pkg::dp_status_t status
);
  import epsm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && action == ACT_SAMPLE) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (status.speed_zero || status.div_last) state_next = ST_PUT;
      end
      ST_PUT: begin
        if (status.out_free) state_next = status.last_chan ? ST_IDLE : ST_LOAD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_LOAD: cmd.load = 1'b1;
      ST_DIV:  cmd.div_step = !status.speed_zero;
      ST_PUT:  cmd.put = status.out_free;
      default: ;
    endcase
  end

  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && !status.speed_zero && !status.div_last |=> state == ST_DIV)
    else $error("divider left before last step");

  a_last_put_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_PUT && status.out_free && status.last_chan |=> state == ST_IDLE)
    else $error("sample run did not end after last wheel");

endmodule

[rtl/core/epsm_dp.sv]
// Datapath: wheel state, time counter, serial divider and result register.
module epsm_dp #(
  parameter int CHANNELS = epsm_pkg::CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  epsm_pkg::dp_cmd_t     cmd,
  output epsm_pkg::dp_status_t  status,
  input  logic [1:0]            action,
  input  logic [1:0]            wheel,
  input  logic [15:0]           debounce_floor_ms,
  input  logic [15:0]           stall_timeout_ms,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [1:0]            channel,
  output logic [19:0]           speed_rpm_q4,
  output logic [31:0]           pulses,
  output logic                  last_of_run
);
  import epsm_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SHOWN = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;
  localparam logic [1:0] LAST_CHAN = 2'(SHOWN - 1);

  logic [31:0] now_ms;
  logic [31:0] pulse_total     [CHANNELS];
  logic [31:0] last_pulse_time [CHANNELS];
  logic [31:0] accepted_period [CHANNELS];
  logic [CHANNELS-1:0] seen_pulse;

  logic [1:0]        chan;
  logic [31:0]       period;
  logic [31:0]       rem;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic              speed_zero;
  logic [31:0]       pulses_snap;

  logic [IDX_W-1:0] idx;
  logic             wheel_ok;
  logic [31:0]      elapsed;
  logic [32:0]      rem_sh;
  logic [32:0]      diff;
  logic             q_bit;
  logic             out_free;

  assign idx      = cmd.accept ? IDX_W'(wheel) : IDX_W'(chan);
  assign wheel_ok = 32'(wheel) < 32'(CHANNELS);
  assign elapsed  = now_ms - last_pulse_time[idx];

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem, SPEED_NUM_Q4[step]};
  assign diff   = rem_sh - {1'b0, period};
  assign q_bit  = !diff[32];

  assign out_free = !out_valid || !out_stall;

  assign status.div_last   = (step == '0);
  assign status.speed_zero = speed_zero;
  assign status.last_chan  = (chan == LAST_CHAN);
  assign status.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms     <= '0;
      seen_pulse <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pulse_total[i]     <= '0;
        last_pulse_time[i] <= '0;
        accepted_period[i] <= '0;
      end
      chan      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        priority case (action)
          ACT_TICK: now_ms <= now_ms + 32'd1;
          ACT_PULSE: begin
            if (wheel_ok) begin
              pulse_total[idx] <= pulse_total[idx] + 32'd1;
              if (seen_pulse[idx]) begin
                if (elapsed >= {16'b0, debounce_floor_ms}) accepted_period[idx] <= elapsed;
              end else begin
                seen_pulse[idx] <= 1'b1;
              end
              last_pulse_time[idx] <= now_ms;
            end
          end
          ACT_SAMPLE: chan <= '0;
          default: ;
        endcase
      end
      if (cmd.load) begin
        period      <= accepted_period[idx];
        rem         <= '0;
        quo         <= '0;
        step        <= STEP_W'(QUO_W - 1);
        speed_zero  <= !seen_pulse[idx] || (accepted_period[idx] == '0) ||
                       (elapsed > {16'b0, stall_timeout_ms});
        pulses_snap <= pulse_total[idx];
      end
      if (cmd.div_step) begin
        rem <= q_bit ? diff[31:0] : rem_sh[31:0];
        quo <= {quo[QUO_W-2:0], q_bit};
        if (step != '0) step <= step - STEP_W'(1);
      end
      if (cmd.put) begin
        out_valid    <= 1'b1;
        channel      <= chan;
        speed_rpm_q4 <= speed_zero ? '0 : quo;
        pulses       <= pulses_snap;
        last_of_run  <= (chan == LAST_CHAN);
        chan         <= chan + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_step: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> step == STEP_W'(QUO_W - 1))
    else $error("divider step count not armed on load");

  a_put_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.put |=> out_valid)
    else $error("result transfer not presented after put");

endmodule

[rtl/core/encoder_period_speed_meter_unit.sv]
// Top level of the encoder period speed meter.
// Tick, pulse and unused items leave intake open, so the next item is taken in the following cycle.
// Sample: for each reported wheel, the first min(CHANNELS,4), a load, the divider steps (cut short
// if the speed reads zero) and a result put, which an output stall holds back; intake reopens
// only after the last wheel's result is put.
// Synchronous reset clears all wheel state, the ms counter and the registers to defaults.
module encoder_period_speed_meter_unit #(
  parameter int CHANNELS = epsm_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [1:0]  wheel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  channel,
  output logic [19:0] speed_rpm_q4,
  output logic [31:0] pulses,
  output logic        last_of_run
);
  import epsm_pkg::*;

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [15:0] debounce_floor_ms;
  logic [15:0] stall_timeout_ms;

  epsm_regs u_regs (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .debounce_floor_ms (debounce_floor_ms),
    .stall_timeout_ms  (stall_timeout_ms)
  );

  epsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  epsm_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .action            (action),
    .wheel             (wheel),
    .debounce_floor_ms (debounce_floor_ms),
    .stall_timeout_ms  (stall_timeout_ms),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .channel           (channel),
    .speed_rpm_q4      (speed_rpm_q4),
    .pulses            (pulses),
    .last_of_run       (last_of_run)
  );

endmodule

[bench/epsm_speed_checker.sv]
// Encoder speed meter checker: follows items and aligned writes; predicts, compares reports.
module epsm_speed_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [1:0]  wheel,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  channel,
  input  logic [19:0] speed_rpm_q4,
  input  logic [31:0] pulses,
  input  logic        last_of_run,
  output int          errors,
  output int          pending,
  output int          reports_checked
);
  import epsm_pkg::*;

  localparam int NCH   = CHANNELS_DEF;
  localparam int SHOWN = (NCH < MAX_RESULTS) ? NCH : MAX_RESULTS;

  typedef struct packed {
    logic [1:0]  channel;
    logic [19:0] speed;
    logic [31:0] pulses;
    logic        last;
  } speed_report_t;

  speed_report_t wheel_reports[$];

  logic [15:0] floor_ms;
  logic [15:0] timeout_ms;
  logic [31:0] clock_ms;
  logic [31:0] hit_total [NCH];
  logic [31:0] last_seen_ms [NCH];
  logic [31:0] held_period [NCH];
  logic        pulsed [NCH];
  logic [19:0] sampled_speed [NCH];

  function automatic logic [19:0] rpm_q4_of(int w);
    logic [31:0] gap;
    logic [31:0] quot;
    gap = clock_ms - last_seen_ms[w];
    if (!pulsed[w] || held_period[w] == 32'd0) return 20'd0;
    if (gap > {16'd0, timeout_ms}) return 20'd0;
    quot = {12'd0, SPEED_NUM_Q4} / held_period[w];
    return quot[19:0];
  endfunction

  task automatic clear_meter();
    int w;
    floor_ms   = DEBOUNCE_RST;
    timeout_ms = TIMEOUT_RST;
    clock_ms   = 32'd0;
    for (w = 0; w < NCH; w++) begin
      hit_total[w]     = 32'd0;
      last_seen_ms[w]  = 32'd0;
      held_period[w]   = 32'd0;
      pulsed[w]        = 1'b0;
      sampled_speed[w] = 20'd0;
    end
    wheel_reports.delete();
  endtask

  task automatic take_item(input logic [1:0] act, input logic [1:0] whl);
    logic [31:0]   gap;
    speed_report_t rep;
    int            w;
    case (act)
      ACT_TICK: clock_ms = clock_ms + 32'd1;
      ACT_PULSE: begin
        if (int'(whl) < NCH) begin
          hit_total[whl] = hit_total[whl] + 32'd1;
          if (pulsed[whl]) begin
            gap = clock_ms - last_seen_ms[whl];
            if (gap >= {16'd0, floor_ms}) held_period[whl] = gap;
          end else begin
            pulsed[whl] = 1'b1;
          end
          last_seen_ms[whl] = clock_ms;
        end
      end
      ACT_SAMPLE: begin
        for (w = 0; w < NCH; w++) sampled_speed[w] = rpm_q4_of(w);
        for (w = 0; w < SHOWN; w++) begin
          rep.channel = w[1:0];
          rep.speed   = sampled_speed[w];
          rep.pulses  = hit_total[w];
          rep.last    = (w == SHOWN - 1);
          wheel_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    speed_report_t want;
    if (rst) begin
      clear_meter();
    end else begin
      if (out_valid && !out_stall) begin
        if (wheel_reports.size() == 0) begin
          errors++;
          $display("%0t: report with none expected: channel %0d speed %0d pulses %0d last %0b",
                   $time, channel, speed_rpm_q4, pulses, last_of_run);
        end else begin
          want = wheel_reports.pop_front();
          reports_checked++;
          if (channel !== want.channel) begin
            errors++;
            $display("%0t: channel expected %0d actual %0d", $time, want.channel, channel);
          end
          if (speed_rpm_q4 !== want.speed) begin
            errors++;
            $display("%0t: speed_rpm_q4 ch%0d expected %0d actual %0d",
                     $time, want.channel, want.speed, speed_rpm_q4);
          end
          if (pulses !== want.pulses) begin
            errors++;
            $display("%0t: pulses ch%0d expected %0d actual %0d",
                     $time, want.channel, want.pulses, pulses);
          end
          if (last_of_run !== want.last) begin
            errors++;
            $display("%0t: last_of_run ch%0d expected %0b actual %0b",
                     $time, want.channel, want.last, last_of_run);
          end
        end
      end
      if (in_valid && !in_stall) take_item(action, wheel);
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[2] == REG_DEBOUNCE) floor_ms = pwdata[15:0];
        else if (paddr[2] == REG_TIMEOUT) timeout_ms = pwdata[15:0];
      end
    end
    pending = wheel_reports.size();
  end

endmodule

[bench/tb_encoder_period_speed_meter_unit.sv]
// Testbench top for the encoder speed meter: stimulus, receiver stalls and the verdict.
module tb_encoder_period_speed_meter_unit;
  import epsm_pkg::*;

  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam logic [2:0] ADDR_DEBOUNCE = {REG_DEBOUNCE, 2'b00};
  localparam logic [2:0] ADDR_TIMEOUT  = {REG_TIMEOUT, 2'b00};
  localparam int         CYCLE_LIMIT   = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [1:0]  wheel;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  channel;
  logic [19:0] speed_rpm_q4;
  logic [31:0] pulses;
  logic        last_of_run;

  int errors;
  int pending;
  int reports_checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int samples_sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  encoder_period_speed_meter_unit u_dut (.*);

  epsm_speed_checker u_check (.*);

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [1:0] whl);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action   = act;
    wheel    = whl;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    if (act == ACT_SAMPLE) samples_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(ACT_TICK, 2'($urandom_range(3)));
  endtask

  // wait for all reports, then give the block time to finish any item still in flight
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
    logic [15:0] junk;
    junk    = 16'($urandom);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {junk, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input logic [15:0] floor_v, input logic [15:0] timeout_v);
    settle();
    write_reg(ADDR_DEBOUNCE, floor_v);
    write_reg(ADDR_TIMEOUT, timeout_v);
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(99);
    if (r < 35) send_ticks($urandom_range(1, 4));
    else if (r < 38) send_ticks($urandom_range(15, 40));
    else if (r < 72) send_item(ACT_PULSE, 2'($urandom_range(3)));
    else if (r < 92) send_item(ACT_SAMPLE, 2'($urandom_range(3)));
    else send_item(ACT_UNUSED, 2'($urandom_range(3)));
  endtask

  initial begin
    int phase;
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = 3'd0;
    pwdata   = 32'd0;
    in_valid = 1'b0;
    action   = ACT_TICK;
    wheel    = 2'd0;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: first pulse, short interval, timeout with a short limit, unused code
    set_config(DEBOUNCE_RST, 16'd12);
    send_item(ACT_SAMPLE, 2'd3);
    send_item(ACT_PULSE, 2'd0);
    send_item(ACT_SAMPLE, 2'd1);
    send_ticks(1);
    send_item(ACT_PULSE, 2'd0);
    send_ticks(3);
    send_item(ACT_PULSE, 2'd0);
    send_item(ACT_PULSE, 2'd1);
    send_ticks(7);
    send_item(ACT_PULSE, 2'd1);
    send_item(ACT_UNUSED, 2'd2);
    send_item(ACT_SAMPLE, 2'd0);
    send_ticks(13);
    send_item(ACT_SAMPLE, 2'd2);
    send_item(ACT_PULSE, 2'd1);
    send_item(ACT_SAMPLE, 2'd0);
    // zero floor and zero timeout: period 0, period 1 at full speed, instant stall
    set_config(16'd0, 16'd0);
    send_item(ACT_PULSE, 2'd2);
    send_item(ACT_PULSE, 2'd2);
    send_item(ACT_PULSE, 2'd3);
    send_ticks(1);
    send_item(ACT_PULSE, 2'd3);
    send_item(ACT_SAMPLE, 2'd1);
    send_ticks(1);
    send_item(ACT_SAMPLE, 2'd3);
    set_config(16'hFFFF, 16'hFFFF);
    send_ticks(3);
    send_item(ACT_PULSE, 2'd0);
    send_item(ACT_SAMPLE, 2'd0);

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(DEBOUNCE_RST, TIMEOUT_RST);
        1: set_config(16'($urandom_range(8)), 16'($urandom_range(20, 200)));
        2: set_config(16'd0, 16'd0);
        3: set_config(16'hFFFF, 16'hFFFF);
        default: set_config(16'd1, 16'($urandom_range(16'hFFFF)));
      endcase
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      repeat (15) random_step();
      if (phase == 1) begin
        // long receiver hold-off with the sender still pushing, then a full drain
        settle();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 400;
        send_item(ACT_SAMPLE, 2'd0);
        send_item(ACT_PULSE, 2'd2);
        send_ticks(3);
        send_item(ACT_PULSE, 2'd2);
        send_item(ACT_SAMPLE, 2'd1);
        send_item(ACT_SAMPLE, 2'd2);
        settle();
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    $display("Sent %0d items incl. %0d samples; %0d wheel reports compared.",
             items_sent, samples_sent, reports_checked);
    $display("Covered extreme floor and timeout values, stalls, idles and a long hold-off.");
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/epsm_pkg.sv
rtl/core/epsm_regs.sv
rtl/core/epsm_ctrl.sv
rtl/core/epsm_dp.sv
rtl/core/encoder_period_speed_meter_unit.sv
bench/epsm_speed_checker.sv
bench/tb_encoder_period_speed_meter_unit.sv
